@@ hdl/wphs_pkg.sv @@
`timescale 1ns / 1ps
// wphs_pkg: shared types and constants for waypoint_heading_steer
// holds field widths, angle constants, the cordic arctangent table and register indexes
// no dependencies
package wphs_pkg;

    localparam int POS_W   = 16;
    localparam int DXY_W   = 17;
    localparam int XY_W    = 28;
    localparam int Z_W     = 25;
    localparam int ANG_W   = 15;
    localparam int ERR_W   = 16;
    localparam int TOL_W   = 14;
    localparam int RATE_W  = 12;
    localparam int TURN_W  = 13;
    localparam int WHEEL_W = 14;
    localparam int CFG_W   = 14;
    localparam int PRE_SHIFT = 8;
    localparam int ROUND_SHIFT = 10;

    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [Z_W-1:0] Z_ROUND_HALF = 25'sd512;
    localparam logic signed [Z_W-1:0] Z_DEG90      = 25'sd5898240;
    localparam logic signed [Z_W-1:0] Z_DEG180     = 25'sd11520;

    localparam logic signed [ERR_W-1:0] DEG90_16  = 16'sd5760;
    localparam logic signed [ERR_W-1:0] DEG180_16 = 16'sd11520;
    localparam logic signed [ERR_W-1:0] DEG360_16 = 16'sd23040;

    localparam logic [TOL_W-1:0]  RST_ANGLE_TOL = 14'd512;
    localparam logic [RATE_W-1:0] RST_TURN_RATE = 12'd230;
    localparam logic [RATE_W-1:0] RST_FWD_RATE  = 12'd1280;

    // atan(2^-i) in 2^-16 degree, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
        25'sd234379,  25'sd117304,  25'sd58666,  25'sd29335,
        25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
        25'sd917,     25'sd458,     25'sd229,    25'sd115,
        25'sd57,      25'sd29,      25'sd14,     25'sd7,
        25'sd4,       25'sd2,       25'sd1,      25'sd0
    };

    typedef enum logic [1:0] {
        CFG_ANGLE_TOL    = 2'd0,
        CFG_TURN_RATE    = 2'd1,
        CFG_FORWARD_RATE = 2'd2
    } cfg_index_t;

endpackage

@@ hdl/waypoint_heading_steer.sv @@
`timescale 1ns / 1ps
// waypoint_heading_steer: bearing to waypoint and wheel speed steering
// pipelined vectoring cordic followed by the heading and velocity hold stage
// depends on wphs_pkg
//
// usage:
//   input channel in_valid/in_ready carries one pose, target point, current
//   heading and the aim and steer enables per transaction
//   output channel out_valid/out_ready returns the held bearing, heading
//   error, forward and turn velocity commands and both wheel setpoints
//   cfg_we/cfg_index/cfg_wdata writes angle_tolerance (0), turn_rate (1)
//   and forward_rate (2); other indexes are ignored
// throughput: one transaction per cycle while the output is not stalled, with
//   one cordic iteration per pipeline stage and the held bearing and velocity
//   registers at the tail
// the whole pipeline advances when the output register is empty or taken;
//   while the receiver stalls a full output, in_ready is low
// reset clears all stage valid bits, the held bearing, velocities and
//   setpoints, and loads the default register values
module waypoint_heading_steer
    import wphs_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [POS_W-1:0]   robot_x,
    input  logic signed [POS_W-1:0]   robot_y,
    input  logic signed [POS_W-1:0]   target_x,
    input  logic signed [POS_W-1:0]   target_y,
    input  logic signed [ANG_W-1:0]   current_angle,
    input  logic                      aim_enable,
    input  logic                      steer_enable,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [ANG_W-1:0]   desired_angle,
    output logic signed [ERR_W-1:0]   angle_error,
    output logic [RATE_W-1:0]         forward_velocity,
    output logic signed [TURN_W-1:0]  turn_velocity,
    output logic signed [WHEEL_W-1:0] left_setpoint,
    output logic signed [WHEEL_W-1:0] right_setpoint,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [CFG_W-1:0]          cfg_wdata
);

    localparam int N = CORDIC_STAGES;

    logic                    adv;

    logic [TOL_W-1:0]        angle_tol_reg;
    logic [RATE_W-1:0]       turn_rate_reg;
    logic [RATE_W-1:0]       fwd_rate_reg;

    logic                    a_valid_reg;
    logic signed [DXY_W-1:0] a_dx_reg;
    logic signed [DXY_W-1:0] a_dy_reg;
    logic signed [ANG_W-1:0] a_cur_reg;
    logic                    a_aim_reg;
    logic                    a_steer_reg;

    logic signed [XY_W-1:0]  x_ext;
    logic signed [XY_W-1:0]  y_ext;
    logic signed [XY_W-1:0]  x_next;
    logic signed [XY_W-1:0]  y_next;
    logic signed [Z_W-1:0]   z_next;

    logic                    c_valid_reg [N+1];
    logic signed [XY_W-1:0]  x_reg       [N+1];
    logic signed [XY_W-1:0]  y_reg       [N+1];
    logic signed [Z_W-1:0]   z_reg       [N+1];
    logic                    c_zero_reg  [N+1];
    logic signed [ANG_W-1:0] c_cur_reg   [N+1];
    logic                    c_aim_reg   [N+1];
    logic                    c_steer_reg [N+1];

    logic signed [Z_W-1:0]   z_round;
    logic signed [ANG_W-1:0] r_bearing_next;
    logic                    r_valid_reg;
    logic signed [ANG_W-1:0] r_bearing_reg;
    logic signed [ANG_W-1:0] r_cur_reg;
    logic                    r_aim_reg;
    logic                    r_steer_reg;

    logic signed [ERR_W-1:0] d_diff;
    logic signed [ANG_W-1:0] d_angle_next;
    logic                    d_valid_reg;
    logic signed [ANG_W-1:0] d_angle_reg;
    logic signed [ANG_W-1:0] d_cur_reg;
    logic                    d_aim_reg;
    logic                    d_steer_reg;

    logic signed [ANG_W-1:0]   held_bearing_next;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [ERR_W:0]     err_wide;
    logic signed [ERR_W:0]     tol_wide;
    logic                      aligned;
    logic signed [TURN_W-1:0]  turn_pos;
    logic signed [TURN_W-1:0]  turn_sel;
    logic signed [WHEEL_W-1:0] turn_wide;

    logic                      out_valid_reg;
    logic signed [ANG_W-1:0]   held_bearing_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic [RATE_W-1:0]         held_forward_reg;
    logic signed [TURN_W-1:0]  held_turn_reg;
    logic signed [WHEEL_W-1:0] left_reg;
    logic signed [WHEEL_W-1:0] right_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_tol_reg <= RST_ANGLE_TOL;
            turn_rate_reg <= RST_TURN_RATE;
            fwd_rate_reg  <= RST_FWD_RATE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ANGLE_TOL:    angle_tol_reg <= cfg_wdata[TOL_W-1:0];
                CFG_TURN_RATE:    turn_rate_reg <= cfg_wdata[RATE_W-1:0];
                CFG_FORWARD_RATE: fwd_rate_reg  <= cfg_wdata[RATE_W-1:0];
                default:          ;
            endcase
        end
    end

    // valid bits of all stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= N; i++)
            begin
                c_valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_valid_reg    <= in_valid;
            c_valid_reg[0] <= a_valid_reg;
            for (int i = 0; i < N; i++)
            begin
                c_valid_reg[i+1] <= c_valid_reg[i];
            end
            r_valid_reg   <= c_valid_reg[N];
            d_valid_reg   <= r_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    // input register: target offset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dx_reg    <= DXY_W'(target_x) - DXY_W'(robot_x);
            a_dy_reg    <= DXY_W'(target_y) - DXY_W'(robot_y);
            a_cur_reg   <= current_angle;
            a_aim_reg   <= aim_enable;
            a_steer_reg <= steer_enable;
        end
    end

    // scale and pre-rotate into the right half plane
    always_comb
    begin
        x_ext  = {{(XY_W-DXY_W-PRE_SHIFT){a_dx_reg[DXY_W-1]}}, a_dx_reg, PRE_SHIFT'(0)};
        y_ext  = {{(XY_W-DXY_W-PRE_SHIFT){a_dy_reg[DXY_W-1]}}, a_dy_reg, PRE_SHIFT'(0)};
        x_next = x_ext;
        y_next = y_ext;
        z_next = '0;
        if (a_dx_reg[DXY_W-1])
        begin
            if (!a_dy_reg[DXY_W-1])
            begin
                x_next = y_ext;
                y_next = -x_ext;
                z_next = Z_DEG90;
            end
            else
            begin
                x_next = -y_ext;
                y_next = x_ext;
                z_next = -Z_DEG90;
            end
        end
    end

    // cordic vectoring pipeline, one iteration per stage
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]       <= x_next;
            y_reg[0]       <= y_next;
            z_reg[0]       <= z_next;
            c_zero_reg[0]  <= (a_dx_reg == '0) && (a_dy_reg == '0);
            c_cur_reg[0]   <= a_cur_reg;
            c_aim_reg[0]   <= a_aim_reg;
            c_steer_reg[0] <= a_steer_reg;
            for (int i = 0; i < N; i++)
            begin
                if (!y_reg[i][XY_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                c_zero_reg[i+1]  <= c_zero_reg[i];
                c_cur_reg[i+1]   <= c_cur_reg[i];
                c_aim_reg[i+1]   <= c_aim_reg[i];
                c_steer_reg[i+1] <= c_steer_reg[i];
            end
        end
    end

    // round to 1/64 degree and saturate; a zero offset gives a zero bearing
    always_comb
    begin
        z_round = (z_reg[N] + Z_ROUND_HALF) >>> ROUND_SHIFT;
        if (c_zero_reg[N])
        begin
            r_bearing_next = '0;
        end
        else if (z_round > Z_DEG180)
        begin
            r_bearing_next = ANG_W'(Z_DEG180);
        end
        else if (z_round < -Z_DEG180)
        begin
            r_bearing_next = ANG_W'(-Z_DEG180);
        end
        else
        begin
            r_bearing_next = z_round[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_bearing_reg <= r_bearing_next;
            r_cur_reg     <= c_cur_reg[N];
            r_aim_reg     <= c_aim_reg[N];
            r_steer_reg   <= c_steer_reg[N];
        end
    end

    // subtract 90 degrees, wrap at -180
    always_comb
    begin
        d_diff = ERR_W'(r_bearing_reg) - DEG90_16;
        if (d_diff <= -DEG180_16)
        begin
            d_angle_next = ANG_W'(d_diff + DEG360_16);
        end
        else
        begin
            d_angle_next = d_diff[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_angle_reg <= d_angle_next;
            d_cur_reg   <= r_cur_reg;
            d_aim_reg   <= r_aim_reg;
            d_steer_reg <= r_steer_reg;
        end
    end

    // heading error and steering decision
    always_comb
    begin
        held_bearing_next = d_aim_reg ? d_angle_reg : held_bearing_reg;
        err_next  = ERR_W'(held_bearing_next) - ERR_W'(d_cur_reg);
        err_wide  = (ERR_W+1)'(err_next);
        tol_wide  = (ERR_W+1)'({1'b0, angle_tol_reg});
        aligned   = (err_wide <= tol_wide) && (err_wide >= -tol_wide);
        turn_pos  = TURN_W'({1'b0, turn_rate_reg});
        turn_sel  = (err_next > 0) ? turn_pos : -turn_pos;
        turn_wide = WHEEL_W'(turn_sel);
    end

    always_ff @(posedge clk)
    begin
        if (adv && d_valid_reg)
        begin
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bearing_reg <= '0;
            held_forward_reg <= '0;
            held_turn_reg    <= '0;
            left_reg         <= '0;
            right_reg        <= '0;
        end
        else if (adv && d_valid_reg)
        begin
            held_bearing_reg <= held_bearing_next;
            if (d_steer_reg)
            begin
                if (aligned)
                begin
                    held_forward_reg <= fwd_rate_reg;
                    held_turn_reg    <= '0;
                    left_reg         <= WHEEL_W'({1'b0, fwd_rate_reg});
                    right_reg        <= WHEEL_W'({1'b0, fwd_rate_reg});
                end
                else
                begin
                    held_forward_reg <= '0;
                    held_turn_reg    <= turn_sel;
                    left_reg         <= -turn_wide;
                    right_reg        <= turn_wide;
                end
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign desired_angle    = held_bearing_reg;
    assign angle_error      = err_reg;
    assign forward_velocity = held_forward_reg;
    assign turn_velocity    = held_turn_reg;
    assign left_setpoint    = left_reg;
    assign right_setpoint   = right_reg;

`ifndef SYNTHESIS
    a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (held_turn_reg == '0) || (held_forward_reg == '0))
        else $error("forward and turn commands both nonzero");

    a_wheel_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (WHEEL_W'(left_reg + right_reg) == WHEEL_W'({1'b0, held_forward_reg, 1'b0})))
        else $error("wheel setpoints disagree with forward command");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ERR_W'(held_bearing_reg) > -DEG180_16) && (ERR_W'(held_bearing_reg) <= DEG180_16))
        else $error("held bearing outside (-180, 180]");

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && !out_ready))
        else $error("input stalled without a waiting result");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> $stable(held_bearing_reg) && $stable(held_turn_reg))
        else $error("held state changed while output stalled");
`endif

endmodule
